// ===== hdl/aled_pkg.sv =====
`timescale 1ns / 1ps

package aled_pkg;

   // request modes
   localparam logic [1:0] MODE_SET  = 2'd0;
   localparam logic [1:0] MODE_FILL = 2'd1;
   localparam logic [1:0] MODE_SHOW = 2'd2;
   localparam logic [1:0] MODE_TICK = 2'd3;

   // line phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_HIGH  = 2'd1;
   localparam logic [1:0] PH_LOW   = 2'd2;
   localparam logic [1:0] PH_LATCH = 2'd3;

   // csr indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LATCH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH    = 3'd5;

   // csr reset values
   localparam logic [7:0]  RST_ONE_HIGH  = 8'd16;
   localparam logic [7:0]  RST_ONE_LOW   = 8'd9;
   localparam logic [7:0]  RST_ZERO_HIGH = 8'd8;
   localparam logic [7:0]  RST_ZERO_LOW  = 8'd17;
   localparam logic [11:0] RST_LATCH     = 12'd1200;
   localparam logic [6:0]  RST_LENGTH    = 7'd59;

   localparam logic [4:0] TOP_BIT = 5'd23;
   localparam int PIX_W = 24;

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] pixel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
   } rsp_type;

endpackage

// ===== hdl/addressable_led_strip_driver.sv =====
`timescale 1ns / 1ps

// Addressable LED strip driver: frame store of 64 (MAX_LEDS) GRB pixel words
// and a one-wire serializer paced by tick transactions. A transaction is taken
// when start is high and busy is low; its result shows on rsp_data for exactly
// one cycle, in the cycle after, flagged by rsp_valid, and cannot be stalled.
// Set-pixel and plain tick transactions leave busy low. A show that starts a
// non-empty frame, and a tick that ends the last bit of a pixel with more
// pixels to go, raise busy while the next pixel word is fetched from the
// frame store, whose read data is registered. A show that is dropped because
// a frame is still being sent, or that finds an empty strip, leaves busy low.
// A fill writes one pixel per cycle, so busy stays high after the fill
// transaction until the sweep has written the effective strip length
// (strip_length capped at the smaller of MAX_LEDS and 127). Reset needs no
// clearing pass: per-entry valid bits make never-written pixels read as zero.
// The CSR port is always ready; write it only while no transaction is in flight.
module addressable_led_strip_driver
   import aled_pkg::*;
#(
   parameter int MAX_LEDS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // transaction request
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   // transaction result
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AddrW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   // effective length cap; strip_length is only 7 bits wide
   localparam int LenCap = (MAX_LEDS > 127) ? 127 : MAX_LEDS;
   localparam logic [6:0] LEN_CAP = 7'(LenCap);

   // ---------------------------------------------------------------- CSRs
   logic [7:0]  one_high_ff, one_low_ff, zero_high_ff, zero_low_ff;
   logic [11:0] latch_ff;
   logic [6:0]  length_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         one_high_ff  <= RST_ONE_HIGH;
         one_low_ff   <= RST_ONE_LOW;
         zero_high_ff <= RST_ZERO_HIGH;
         zero_low_ff  <= RST_ZERO_LOW;
         latch_ff     <= RST_LATCH;
         length_ff    <= RST_LENGTH;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ONE_HIGH:  one_high_ff  <= csr_wdata[7:0];
            CSR_ONE_LOW:   one_low_ff   <= csr_wdata[7:0];
            CSR_ZERO_HIGH: zero_high_ff <= csr_wdata[7:0];
            CSR_ZERO_LOW:  zero_low_ff  <= csr_wdata[7:0];
            CSR_LATCH:     latch_ff     <= csr_wdata[11:0];
            CSR_LENGTH:    length_ff    <= csr_wdata[6:0];
            default: ;     // unmapped index: dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- state
   logic [1:0]       send_phase_ff, send_phase_in;
   logic [6:0]       send_pixel_ff, send_pixel_in;
   logic [4:0]       send_bit_ff,   send_bit_in;
   logic [PIX_W-1:0] send_word_ff;
   logic [11:0]      tick_count_ff, tick_count_in;
   logic             load_ff, load_in;       // fetch in flight
   logic             word_clr;
   logic             fill_active_ff, fill_active_in;
   logic [6:0]       fill_cnt_ff, fill_cnt_in;
   logic [PIX_W-1:0] fill_word_ff, fill_word_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic [6:0]       len;
   logic [PIX_W-1:0] req_word;
   logic [11:0]      tick_inc;
   logic             cur_bit;
   logic [7:0]       lim8;
   logic [6:0]       pix_next;
   logic [7:0]       fill_next;

   // memory port
   logic             mem_wr_en;
   logic [AddrW-1:0] mem_wr_addr;
   logic [PIX_W-1:0] mem_wr_data;
   logic [6:0]       rd_pixel;
   logic [PIX_W-1:0] mem_rd_data;

   assign busy     = load_ff | fill_active_ff;
   assign accept   = start & ~busy;
   assign len      = (length_ff > LEN_CAP) ? LEN_CAP : length_ff;
   assign req_word = {req_data.green, req_data.red, req_data.blue};
   assign tick_inc = tick_count_ff + 12'd1;
   assign cur_bit  = send_word_ff[send_bit_ff];
   assign pix_next = send_pixel_ff + 7'd1;
   assign fill_next = {1'b0, fill_cnt_ff} + 8'd1;

   always_comb begin
      send_phase_in  = send_phase_ff;
      send_pixel_in  = send_pixel_ff;
      send_bit_in    = send_bit_ff;
      tick_count_in  = tick_count_ff;
      load_in        = 1'b0;
      word_clr       = 1'b0;
      fill_active_in = fill_active_ff;
      fill_cnt_in    = fill_cnt_ff;
      fill_word_in   = fill_word_ff;
      rd_pixel       = send_pixel_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = AddrW'(req_data.pixel_index);
      mem_wr_data    = req_word;
      lim8           = 8'd0;
      rsp_in         = '0;

      // fill sweep, one pixel per cycle
      if (fill_active_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = AddrW'(fill_cnt_ff);
         mem_wr_data = fill_word_ff;
         fill_cnt_in = fill_next[6:0];
         if (fill_next >= {1'b0, len}) begin
            fill_active_in = 1'b0;
         end
      end

      if (accept) begin
         case (req_data.mode)
            MODE_TICK: begin
               rsp_in.line_level = (send_phase_ff == PH_HIGH);
               rsp_in.busy_res   = (send_phase_ff != PH_IDLE);
               if (send_phase_ff != PH_IDLE) begin
                  tick_count_in = tick_inc;
               end
               case (send_phase_ff)
                  PH_HIGH: begin
                     lim8 = cur_bit ? one_high_ff : zero_high_ff;
                     if (tick_inc >= {4'd0, lim8}) begin
                        tick_count_in = '0;
                        send_phase_in = PH_LOW;
                     end
                  end
                  PH_LOW: begin
                     lim8 = cur_bit ? one_low_ff : zero_low_ff;
                     if (tick_inc >= {4'd0, lim8}) begin
                        tick_count_in = '0;
                        if (send_bit_ff != 5'd0) begin
                           send_bit_in   = send_bit_ff - 5'd1;
                           send_phase_in = PH_HIGH;
                        end else begin
                           send_pixel_in = pix_next;
                           if (pix_next >= len) begin
                              send_phase_in = PH_LATCH;
                           end else begin
                              // next pixel: fetch its word
                              send_bit_in   = TOP_BIT;
                              send_phase_in = PH_HIGH;
                              load_in       = 1'b1;
                              rd_pixel      = pix_next;
                           end
                        end
                     end
                  end
                  PH_LATCH: begin
                     if (tick_inc >= latch_ff) begin
                        tick_count_in     = '0;
                        send_phase_in     = PH_IDLE;
                        rsp_in.frame_done = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            MODE_SET: begin
               if ({1'b0, req_data.pixel_index} < len) begin
                  mem_wr_en = 1'b1;
               end
            end
            MODE_FILL: begin
               if (len != 7'd0) begin
                  fill_active_in = 1'b1;
                  fill_cnt_in    = '0;
                  fill_word_in   = req_word;
               end
            end
            MODE_SHOW: begin
               if (send_phase_ff == PH_IDLE) begin
                  send_pixel_in = '0;
                  send_bit_in   = TOP_BIT;
                  tick_count_in = '0;
                  if (len == 7'd0) begin
                     word_clr      = 1'b1;
                     send_phase_in = PH_LATCH;
                  end else begin
                     send_phase_in = PH_HIGH;
                     load_in       = 1'b1;
                     rd_pixel      = '0;
                  end
               end
            end
            default: ;
         endcase
         if (req_data.mode != MODE_TICK) begin
            rsp_in.line_level = (send_phase_in == PH_HIGH);
            rsp_in.busy_res   = (send_phase_in != PH_IDLE);
         end
      end
   end

   aled_frame_store #(
      .DEPTH (MAX_LEDS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (AddrW'(rd_pixel)),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         send_phase_ff  <= PH_IDLE;
         send_pixel_ff  <= '0;
         send_bit_ff    <= TOP_BIT;
         send_word_ff   <= '0;
         tick_count_ff  <= '0;
         load_ff        <= 1'b0;
         fill_active_ff <= 1'b0;
         fill_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         send_phase_ff  <= send_phase_in;
         send_pixel_ff  <= send_pixel_in;
         send_bit_ff    <= send_bit_in;
         tick_count_ff  <= tick_count_in;
         load_ff        <= load_in;
         fill_active_ff <= fill_active_in;
         fill_cnt_ff    <= fill_cnt_in;
         rsp_valid_ff   <= accept;
         if (load_ff) begin
            send_word_ff <= mem_rd_data;
         end else if (word_clr) begin
            send_word_ff <= '0;
         end
      end
   end

   // payload only
   always_ff @(posedge clock) begin
      fill_word_ff <= fill_word_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- checks
   a_fetch_starts_bit: assert property (@(posedge clock) disable iff (reset)
      load_ff |-> (send_phase_ff == PH_HIGH) && (send_bit_ff == TOP_BIT)
                  && (tick_count_ff == 12'd0))
      else $error("pixel fetch without fresh bit state");

   a_fill_holds_line: assert property (@(posedge clock) disable iff (reset)
      fill_active_ff |=> $stable(send_phase_ff) && $stable(tick_count_ff))
      else $error("line state moved during fill sweep");

   a_done_in_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.busy_res && !rsp_data.line_level
                                           && (send_phase_ff == PH_IDLE))
      else $error("frame_done outside latch gap end");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      send_bit_ff <= TOP_BIT)
      else $error("bit counter out of range");

   a_fill_no_fetch: assert property (@(posedge clock) disable iff (reset)
      fill_active_ff |-> !load_ff && !accept)
      else $error("fetch or transaction during fill sweep");

endmodule

// ===== hdl/aled_frame_store.sv =====
`timescale 1ns / 1ps

// Pixel memory, one write and one registered read per cycle.
// Entries never written since reset read as zero (per-entry valid bits).
module aled_frame_store
   import aled_pkg::*;
#(
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [PIX_W-1:0] rd_word_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_word_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule
